### hw/rtl/sac_pkg.sv
package sac_pkg;

    // Field formats
    localparam int COORD_BITS    = 24;
    localparam int FRACTION_BITS = 16;
    localparam int SIZE_BITS     = 12;
    localparam int TIME_BITS     = 16;
    localparam int SIZE_SHIFT    = 8;
    localparam int DISP_SHIFT    = 16;

    // Derived datapath widths
    localparam int PROD_BITS = COORD_BITS + TIME_BITS + 1;
    localparam int DWID_BITS = PROD_BITS - DISP_SHIFT;
    localparam int DIST_BITS = COORD_BITS + 2;
    localparam int NUM_BITS  = DIST_BITS + FRACTION_BITS;
    localparam int QUO_BITS  = FRACTION_BITS + 2;
    localparam int RES_BITS  = FRACTION_BITS + 3;
    localparam int FRAC_BITS = FRACTION_BITS + 1;

    // Pipeline depths and result queue size
    localparam int DIV_LAT   = QUO_BITS + 2;
    localparam int FRONT_LAT = 2;
    localparam int BACK_LAT  = DIV_LAT + 1;
    localparam int PIPE_LAT  = FRONT_LAT + BACK_LAT;
    localparam int Q_AW      = $clog2(PIPE_LAT + 2);
    localparam int Q_DEPTH   = 1 << Q_AW;

    // Fraction constants; infinities sit outside the saturation range
    localparam logic signed [RES_BITS-1:0] ONE_FRAC = RES_BITS'(1) << FRACTION_BITS;
    localparam logic [QUO_BITS:0] CLAMP_MAG = (QUO_BITS + 1)'(1) << (FRACTION_BITS + 1);
    localparam logic signed [RES_BITS-1:0] POS_INF = {1'b0, {(RES_BITS - 1){1'b1}}};
    localparam logic signed [RES_BITS-1:0] NEG_INF = {1'b1, {(RES_BITS - 1){1'b0}}};

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_LEFT   = 3'd1,
        SIDE_RIGHT  = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_BOTTOM = 3'd4
    } side_t;

    typedef struct packed {
        logic signed [DIST_BITS-1:0]  din;
        logic signed [DIST_BITS-1:0]  dout;
        logic signed [COORD_BITS-1:0] disp;
        logic                         zero;
        logic                         din_pos;
    } axis_t;

    typedef struct packed {
        logic [FRAC_BITS-1:0] frac;
        side_t                side;
    } result_t;

endpackage

### hw/rtl/sac_front.sv
module sac_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_x,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_y,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  mover_w,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  mover_h,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_vx,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_vy,
    input  logic        [sac_pkg::TIME_BITS-1:0]  delta_time,
    input  logic signed [sac_pkg::COORD_BITS-1:0] target_x,
    input  logic signed [sac_pkg::COORD_BITS-1:0] target_y,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  target_w,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  target_h,
    output logic                                 out_valid,
    output sac_pkg::axis_t                       axis_x,
    output sac_pkg::axis_t                       axis_y
);
    import sac_pkg::*;

    logic                         s1_valid_reg;
    logic signed [PROD_BITS-1:0]  px_reg, py_reg;
    logic signed [COORD_BITS-1:0] mx_reg, my_reg, tx_reg, ty_reg;
    logic [SIZE_BITS-1:0]         mw_reg, mh_reg, tw_reg, th_reg;
    logic                         s2_valid_reg;
    axis_t                        ax_reg, ay_reg, ax_next, ay_next;

    // Saturate the displacement, pick entry and exit distances by its sign
    function automatic axis_t axis_calc(
        input logic signed [PROD_BITS-1:0]  prod,
        input logic signed [COORD_BITS-1:0] mpos,
        input logic [SIZE_BITS-1:0]         msize,
        input logic signed [COORD_BITS-1:0] tpos,
        input logic [SIZE_BITS-1:0]         tsize
    );
        logic signed [DWID_BITS-1:0]  dw;
        logic signed [COORD_BITS-1:0] d;
        logic signed [DIST_BITS-1:0]  mp, tp, ms, ts, near_d, far_d;
        logic                         in_range;
        axis_t                        a;
        dw = prod[PROD_BITS-1:DISP_SHIFT];
        in_range = (&dw[DWID_BITS-1:COORD_BITS-1]) | ~(|dw[DWID_BITS-1:COORD_BITS-1]);
        if (in_range)
            d = dw[COORD_BITS-1:0];
        else
            d = dw[DWID_BITS-1] ? {1'b1, {(COORD_BITS - 1){1'b0}}}
                                : {1'b0, {(COORD_BITS - 1){1'b1}}};
        mp = DIST_BITS'(mpos);
        tp = DIST_BITS'(tpos);
        ms = DIST_BITS'({msize, {SIZE_SHIFT{1'b0}}});
        ts = DIST_BITS'({tsize, {SIZE_SHIFT{1'b0}}});
        near_d = tp - (mp + ms);
        far_d  = (tp + ts) - mp;
        if (d > 0)
        begin
            a.din  = near_d;
            a.dout = far_d;
        end
        else
        begin
            a.din  = far_d;
            a.dout = near_d;
        end
        a.disp    = d;
        a.zero    = (d == '0);
        a.din_pos = (a.din > 0);
        return a;
    endfunction

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Form velocity times step, hold the boxes
    always_ff @(posedge clk)
    begin
        px_reg <= mover_vx * $signed({1'b0, delta_time});
        py_reg <= mover_vy * $signed({1'b0, delta_time});
        mx_reg <= mover_x;
        my_reg <= mover_y;
        tx_reg <= target_x;
        ty_reg <= target_y;
        mw_reg <= mover_w;
        mh_reg <= mover_h;
        tw_reg <= target_w;
        th_reg <= target_h;
    end

    always_comb
    begin
        ax_next = axis_calc(px_reg, mx_reg, mw_reg, tx_reg, tw_reg);
        ay_next = axis_calc(py_reg, my_reg, mh_reg, ty_reg, th_reg);
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= ax_next;
        ay_reg <= ay_next;
    end

    assign out_valid = s2_valid_reg;
    assign axis_x    = ax_reg;
    assign axis_y    = ay_reg;

endmodule

### hw/rtl/sac_div.sv
module sac_div (
    input  logic                                 clk,
    input  logic signed [sac_pkg::NUM_BITS-1:0]   num,
    input  logic signed [sac_pkg::COORD_BITS-1:0] den,
    output logic signed [sac_pkg::RES_BITS-1:0]   quo
);
    import sac_pkg::*;

    logic [NUM_BITS-1:0]   nmag;
    logic [COORD_BITS-1:0] dmag;
    logic [COORD_BITS-1:0] top;

    logic [COORD_BITS-1:0] rem_reg  [0:QUO_BITS];
    logic [QUO_BITS-1:0]   low_reg  [0:QUO_BITS];
    logic [QUO_BITS-1:0]   q_reg    [0:QUO_BITS];
    logic [COORD_BITS-1:0] dmag_reg [0:QUO_BITS];
    logic                  neg_reg  [0:QUO_BITS];
    logic                  ovf_reg  [0:QUO_BITS];

    logic [COORD_BITS-1:0] rem_next [0:QUO_BITS-1];
    logic [QUO_BITS-1:0]   q_next   [0:QUO_BITS-1];

    logic [QUO_BITS:0]           mag;
    logic signed [RES_BITS-1:0]  quo_next, quo_reg;

    // Split into magnitudes; a quotient too wide for the stages saturates
    always_comb
    begin
        nmag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
        dmag = den[COORD_BITS-1] ? COORD_BITS'(-den) : COORD_BITS'(den);
        top  = nmag[NUM_BITS-1:QUO_BITS];
    end

    // One restoring step per stage
    always_comb
    begin
        for (int i = 0; i < QUO_BITS; i++)
        begin
            logic [COORD_BITS:0] trial;
            logic                ge;
            trial = {rem_reg[i], low_reg[i][QUO_BITS-1]};
            ge = (trial >= {1'b0, dmag_reg[i]});
            rem_next[i] = ge ? COORD_BITS'(trial - {1'b0, dmag_reg[i]})
                             : trial[COORD_BITS-1:0];
            q_next[i] = {q_reg[i][QUO_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= top;
        low_reg[0]  <= nmag[QUO_BITS-1:0];
        q_reg[0]    <= '0;
        dmag_reg[0] <= dmag;
        neg_reg[0]  <= num[NUM_BITS-1] ^ den[COORD_BITS-1];
        ovf_reg[0]  <= (top >= dmag);
        for (int i = 0; i < QUO_BITS; i++)
        begin
            rem_reg[i+1]  <= rem_next[i];
            low_reg[i+1]  <= {low_reg[i][QUO_BITS-2:0], 1'b0};
            q_reg[i+1]    <= q_next[i];
            dmag_reg[i+1] <= dmag_reg[i];
            neg_reg[i+1]  <= neg_reg[i];
            ovf_reg[i+1]  <= ovf_reg[i];
        end
    end

    // Round toward minus infinity and clamp beyond two steps
    always_comb
    begin
        if (neg_reg[QUO_BITS] && (rem_reg[QUO_BITS] != '0))
            mag = {1'b0, q_reg[QUO_BITS]} + (QUO_BITS + 1)'(1);
        else
            mag = {1'b0, q_reg[QUO_BITS]};
        if (ovf_reg[QUO_BITS] || (mag > CLAMP_MAG))
            mag = CLAMP_MAG;
        quo_next = neg_reg[QUO_BITS] ? -$signed(RES_BITS'(mag)) : $signed(RES_BITS'(mag));
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

### hw/rtl/sac_back.sv
module sac_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  sac_pkg::axis_t       axis_x,
    input  sac_pkg::axis_t       axis_y,
    output logic                 res_valid,
    output sac_pkg::result_t     res
);
    import sac_pkg::*;

    logic signed [RES_BITS-1:0] qxin, qxout, qyin, qyout;
    logic signed [RES_BITS-1:0] xin, xout, yin, yout, entry, exitt;

    logic valid_dly [0:DIV_LAT-1];
    logic zx_dly    [0:DIV_LAT-1];
    logic zy_dly    [0:DIV_LAT-1];
    logic px_dly    [0:DIV_LAT-1];
    logic py_dly    [0:DIV_LAT-1];

    logic    res_valid_reg;
    result_t res_reg, res_next;
    logic    no_hit;

    sac_div u_div_xin (
        .clk (clk),
        .num ($signed({axis_x.din, {FRACTION_BITS{1'b0}}})),
        .den (axis_x.disp),
        .quo (qxin)
    );

    sac_div u_div_xout (
        .clk (clk),
        .num ($signed({axis_x.dout, {FRACTION_BITS{1'b0}}})),
        .den (axis_x.disp),
        .quo (qxout)
    );

    sac_div u_div_yin (
        .clk (clk),
        .num ($signed({axis_y.din, {FRACTION_BITS{1'b0}}})),
        .den (axis_y.disp),
        .quo (qyin)
    );

    sac_div u_div_yout (
        .clk (clk),
        .num ($signed({axis_y.dout, {FRACTION_BITS{1'b0}}})),
        .den (axis_y.disp),
        .quo (qyout)
    );

    // Carry flags alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                valid_dly[i] <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            valid_dly[0] <= in_valid;
            for (int i = 1; i < DIV_LAT; i++)
                valid_dly[i] <= valid_dly[i-1];
            res_valid_reg <= valid_dly[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        zx_dly[0] <= axis_x.zero;
        zy_dly[0] <= axis_y.zero;
        px_dly[0] <= axis_x.din_pos;
        py_dly[0] <= axis_y.din_pos;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            zx_dly[i] <= zx_dly[i-1];
            zy_dly[i] <= zy_dly[i-1];
            px_dly[i] <= px_dly[i-1];
            py_dly[i] <= py_dly[i-1];
        end
    end

    // Combine axes: latest entry, earliest exit, then hit or no hit
    always_comb
    begin
        xin   = zx_dly[DIV_LAT-1] ? NEG_INF : qxin;
        xout  = zx_dly[DIV_LAT-1] ? POS_INF : qxout;
        yin   = zy_dly[DIV_LAT-1] ? NEG_INF : qyin;
        yout  = zy_dly[DIV_LAT-1] ? POS_INF : qyout;
        entry = (xin > yin) ? xin : yin;
        exitt = (xout < yout) ? xout : yout;
        no_hit = (entry > exitt) || ((xin < 0) && (yin < 0)) ||
                 (xin > ONE_FRAC) || (yin > ONE_FRAC);
        if (no_hit)
        begin
            res_next.frac = ONE_FRAC[FRAC_BITS-1:0];
            res_next.side = SIDE_NONE;
        end
        else
        begin
            res_next.frac = entry[FRAC_BITS-1:0];
            if (xin > yin)
                res_next.side = px_dly[DIV_LAT-1] ? SIDE_RIGHT : SIDE_LEFT;
            else
                res_next.side = py_dly[DIV_LAT-1] ? SIDE_BOTTOM : SIDE_TOP;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### hw/rtl/sac_fifo.sv
module sac_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  sac_pkg::result_t         wr_data,
    input  logic                     rd_en,
    output sac_pkg::result_t         rd_data,
    output logic                     empty,
    output logic [sac_pkg::Q_AW:0]   count
);
    import sac_pkg::*;

    result_t         mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            do_rd;

    assign do_rd = rd_en && (count_reg != '0);

    // Store the item
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            count_reg <= count_reg + (Q_AW + 1)'(wr_en) - (Q_AW + 1)'(do_rd);
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule

### hw/rtl/swept_aabb_collision.sv
// Swept box collision test, one item per clock while full is low.
// Path from the accepting edge to a result on the ports: 2 front stages, 20 stages of
// the shared-width restoring dividers, 1 decision stage, then the queue write.
// A new item is taken every cycle while the result queue drains; push is held off
// only when items in flight plus queued results fill the queue.
// Reset (rst_n low, asynchronous) empties the pipeline and the queue.
module swept_aabb_collision (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_x,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_y,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  mover_w,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  mover_h,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_vx,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_vy,
    input  logic        [sac_pkg::TIME_BITS-1:0]  delta_time,
    input  logic signed [sac_pkg::COORD_BITS-1:0] target_x,
    input  logic signed [sac_pkg::COORD_BITS-1:0] target_y,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  target_w,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  target_h,
    output logic                                 empty,
    input  logic                                 pop,
    output logic        [sac_pkg::FRAC_BITS-1:0]  hit_fraction,
    output logic        [2:0]                    hit_side
);
    import sac_pkg::*;

    logic          accept;
    logic          front_valid;
    axis_t         axis_x, axis_y;
    logic          res_valid;
    result_t       res, q_data;
    logic [Q_AW:0] q_count;
    logic [Q_AW:0] inflight_reg, inflight_next;
    logic [Q_AW+1:0] occupancy;

    assign occupancy = (Q_AW + 2)'(inflight_reg) + (Q_AW + 2)'(q_count);
    assign full      = (occupancy >= (Q_AW + 2)'(Q_DEPTH));
    assign accept    = push && !full;

    sac_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .mover_x    (mover_x),
        .mover_y    (mover_y),
        .mover_w    (mover_w),
        .mover_h    (mover_h),
        .mover_vx   (mover_vx),
        .mover_vy   (mover_vy),
        .delta_time (delta_time),
        .target_x   (target_x),
        .target_y   (target_y),
        .target_w   (target_w),
        .target_h   (target_h),
        .out_valid  (front_valid),
        .axis_x     (axis_x),
        .axis_y     (axis_y)
    );

    sac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .axis_x    (axis_x),
        .axis_y    (axis_y),
        .res_valid (res_valid),
        .res       (res)
    );

    sac_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (q_data),
        .empty   (empty),
        .count   (q_count)
    );

    // Track items in flight so every one has a queue slot waiting
    assign inflight_next = inflight_reg + (Q_AW + 1)'(accept) - (Q_AW + 1)'(res_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    assign hit_fraction = q_data.frac;
    assign hit_side     = q_data.side;

    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (Q_AW + 2)'(Q_DEPTH))
        else $error("in-flight plus queued items exceed queue size");

    a_slot_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (q_count < (Q_AW + 1)'(Q_DEPTH)))
        else $error("result written into a full queue");

    a_none_is_full_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (hit_side == SIDE_NONE)) |-> (hit_fraction == ONE_FRAC[FRAC_BITS-1:0]))
        else $error("no-hit result without a full step");

    a_fraction_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (hit_fraction <= ONE_FRAC[FRAC_BITS-1:0]))
        else $error("hit fraction beyond one step");

endmodule
